### hdl/bcr_pkg.sv
// bcr_pkg: shared constants for the bicubic catmull-rom grid sampler
// used by bcr_cubic and bicubic_catmull_rom_grid_sampler_top
`timescale 1ns / 1ps
package bcr_pkg;

  localparam int DEF_MAX_CONTROL_ROWS    = 16;
  localparam int DEF_MAX_CONTROL_COLUMNS = 16;
  localparam int DEF_MAX_SAMPLES         = 1024;
  localparam int DEF_COORD_BITS          = 32;

  // fixed field widths
  localparam int POINT_W    = 4;
  localparam int SAMPLE_W   = 10;
  localparam int CTRL_CNT_W = 5;
  localparam int SMPL_CNT_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int FRAC_W     = 16;

  // extra integer bits carried by the column pass values
  localparam int VAL_GUARD = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_COLUMNS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_ROWS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COLUMNS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_COLUMNS = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_BAD_CONFIG = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

endpackage

### hdl/bcr_cubic.sv
// bcr_cubic: catmull-rom cubic on four points, horner steps on one multiplier
// depends on bcr_pkg
`timescale 1ns / 1ps
module bcr_cubic
  import bcr_pkg::*;
#(
  parameter int VW = DEF_COORD_BITS + VAL_GUARD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VW-1:0] p0_i,
  input  logic signed [VW-1:0] p1_i,
  input  logic signed [VW-1:0] p2_i,
  input  logic signed [VW-1:0] p3_i,
  input  logic [FRAC_W-1:0]    t_i,
  output logic                 done_o,
  output logic signed [VW-1:0] value_o
);

  localparam int CW = VW + 5;
  localparam int PW = CW + FRAC_W + 1;

  logic                 run_q;
  logic [1:0]           step_q;
  logic                 done_q;
  logic signed [CW-1:0] h_q, a_q, b_q, p1_q;
  logic [FRAC_W-1:0]    t_q;
  logic signed [VW-1:0] value_q;

  logic signed [CW-1:0] e0, e1, e2, e3, coef_a, coef_b, coef_c;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] mf;
  logic signed [CW:0]   fin_sum;

  assign e0 = CW'(p0_i);
  assign e1 = CW'(p1_i);
  assign e2 = CW'(p2_i);
  assign e3 = CW'(p3_i);
  assign coef_a = e2 - e0;
  assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign coef_c = e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;

  // floor(h*t/2^16) is an arithmetic shift of the exact product
  assign prod    = PW'(h_q) * $signed({1'b0, t_q});
  assign mf      = CW'(prod >>> FRAC_W);
  assign fin_sum = (CW+1)'(p1_q <<< 1) + (CW+1)'(mf) + (CW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 2'd0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q  <= coef_c;
      a_q  <= coef_a;
      b_q  <= coef_b;
      p1_q <= e1;
      t_q  <= t_i;
    end else if (run_q) begin
      case (step_q)
        2'd0:    h_q <= b_q + mf;
        2'd1:    h_q <= a_q + mf;
        default: value_q <= VW'(fin_sum >>> 1);
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

### hdl/bicubic_catmull_rom_grid_sampler_top.sv
// bicubic_catmull_rom_grid_sampler_top: control grid store, segment divider, sequencer
// depends on bcr_pkg and bcr_cubic
//
// usage: a beat is taken when start_i is high and busy_o is low. func_i low
// writes one control point into the grid store at once; the block stays idle
// and no result follows. func_i high asks for one sample. a bad configuration
// or an out of range index returns its status on the next cycle with zero
// coordinates. a good sample runs a restoring divider once per axis, then
// per grid row four store reads (registered read port) and three cubic passes
// on the shared multiplier, then three final passes. busy_o stays high
// throughout, so one sample is in flight at a time. the result shows on the
// result ports for one cycle with done_o high; the receiver cannot stall.
// configuration registers are written through cfg_we_i; the user must write
// them only while the block is idle, which the block itself leaves unenforced.
// reset restores the register defaults and idles the sequencer; the grid
// store holds garbage until each point is written.
`timescale 1ns / 1ps
module bicubic_catmull_rom_grid_sampler_top
  import bcr_pkg::*;
#(
  parameter int MAX_CONTROL_ROWS    = DEF_MAX_CONTROL_ROWS,
  parameter int MAX_CONTROL_COLUMNS = DEF_MAX_CONTROL_COLUMNS,
  parameter int MAX_SAMPLES         = DEF_MAX_SAMPLES,
  parameter int COORD_BITS          = DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         func_i,
  input  logic [POINT_W-1:0]           point_row_i,
  input  logic [POINT_W-1:0]           point_column_i,
  input  logic signed [COORD_BITS-1:0] x_in_i,
  input  logic signed [COORD_BITS-1:0] y_in_i,
  input  logic signed [COORD_BITS-1:0] z_in_i,
  input  logic [SAMPLE_W-1:0]          sample_row_i,
  input  logic [SAMPLE_W-1:0]          sample_column_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] x_out_o,
  output logic signed [COORD_BITS-1:0] y_out_o,
  output logic signed [COORD_BITS-1:0] z_out_o,
  output logic [1:0]                   status_o
);

  localparam int VW    = COORD_BITS + VAL_GUARD;
  localparam int RIW   = $clog2(MAX_CONTROL_ROWS);
  localparam int CIW   = $clog2(MAX_CONTROL_COLUMNS);
  localparam int DEPTH = MAX_CONTROL_ROWS * MAX_CONTROL_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 3 * COORD_BITS;
  localparam int NW    = SAMPLE_W + CTRL_CNT_W;
  localparam int DW    = NW + FRAC_W;
  localparam int IW    = CTRL_CNT_W + 2;
  localparam int SW    = $clog2(MAX_SAMPLES + 1) + 1;

  localparam logic signed [VW-1:0] SAT_MAX = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SAT_MIN = -SAT_MAX - VW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVR = 3'd1;
  localparam logic [2:0] S_DIVC = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;
  localparam logic [2:0] S_CST  = 3'd5;
  localparam logic [2:0] S_CW   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // configuration registers
  logic [CTRL_CNT_W-1:0] ctrl_rows_q, ctrl_cols_q;
  logic [SMPL_CNT_W-1:0] smpl_rows_q, smpl_cols_q;
  logic                  periodic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_rows_q <= CTRL_CNT_W'(4);
      ctrl_cols_q <= CTRL_CNT_W'(4);
      smpl_rows_q <= SMPL_CNT_W'(16);
      smpl_cols_q <= SMPL_CNT_W'(16);
      periodic_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CONTROL_ROWS:     ctrl_rows_q <= cfg_data_i[CTRL_CNT_W-1:0];
        CFG_CONTROL_COLUMNS:  ctrl_cols_q <= cfg_data_i[CTRL_CNT_W-1:0];
        CFG_SAMPLE_ROWS:      smpl_rows_q <= cfg_data_i;
        CFG_SAMPLE_COLUMNS:   smpl_cols_q <= cfg_data_i;
        CFG_PERIODIC_COLUMNS: periodic_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // grid store
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_q;
  logic          accept, wr_en, rd_en;
  logic [AW-1:0] waddr, raddr;

  assign accept = start_i && !busy_o;
  assign wr_en  = accept && (func_i == FUNC_WRITE)
                  && (32'(point_row_i) < MAX_CONTROL_ROWS)
                  && (32'(point_column_i) < MAX_CONTROL_COLUMNS);
  assign waddr  = AW'(32'(point_row_i) * MAX_CONTROL_COLUMNS + 32'(point_column_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= {x_in_i, y_in_i, z_in_i};
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[raddr];
  end

  // configuration and index checks
  logic cfg_ok, idx_ok;
  assign cfg_ok = (ctrl_rows_q >= CTRL_CNT_W'(2))
               && (32'(ctrl_rows_q) <= MAX_CONTROL_ROWS)
               && (ctrl_cols_q >= CTRL_CNT_W'(2))
               && (32'(ctrl_cols_q) <= MAX_CONTROL_COLUMNS)
               && (smpl_rows_q >= SMPL_CNT_W'(ctrl_rows_q))
               && (SW'(smpl_rows_q) <= SW'(MAX_SAMPLES))
               && (smpl_cols_q >= SMPL_CNT_W'(ctrl_cols_q))
               && (SW'(smpl_cols_q) <= SW'(MAX_SAMPLES))
               && !(periodic_q && (ctrl_cols_q < CTRL_CNT_W'(3)));
  assign idx_ok = (SMPL_CNT_W'(sample_row_i) < smpl_rows_q)
               && (SMPL_CNT_W'(sample_column_i) < smpl_cols_q);

  // sequencer registers
  logic [2:0]            state_q, state_d;
  logic [4:0]            cnt_q;
  logic [1:0]            row_q, col_q, axis_q;
  logic                  fin_q, done_q;
  logic [1:0]            status_q;
  logic [SAMPLE_W-1:0]   scol_q;
  logic [DW-1:0]         dvd_q, quo_q;
  logic [SMPL_CNT_W-1:0] den_q, rem_q;
  logic [IW-2:0]         rseg_q, cseg_q;
  logic [FRAC_W-1:0]     rt_q, ct_q;
  logic signed [COORD_BITS-1:0] pts_q [4][3];
  logic signed [VW-1:0]  rv_q [4][3];
  logic signed [COORD_BITS-1:0] out_q [3];

  // divider step
  logic [SMPL_CNT_W:0]   rem_sh;
  logic                  qbit;
  logic [SMPL_CNT_W-1:0] rem_nx;
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};
  assign rem_nx = qbit ? SMPL_CNT_W'(rem_sh - {1'b0, den_q}) : SMPL_CNT_W'(rem_sh);

  logic [NW-1:0]         num_row, num_col;
  logic [SMPL_CNT_W-1:0] den_row, den_col;
  assign num_row = NW'(sample_row_i) * NW'(ctrl_rows_q - CTRL_CNT_W'(1));
  assign den_row = smpl_rows_q - SMPL_CNT_W'(1);
  assign num_col = periodic_q ? NW'(scol_q) * NW'(ctrl_cols_q)
                              : NW'(scol_q) * NW'(ctrl_cols_q - CTRL_CNT_W'(1));
  assign den_col = periodic_q ? smpl_cols_q : smpl_cols_q - SMPL_CNT_W'(1);

  // neighbourhood indices: rows clamp, columns clamp or wrap
  logic signed [IW-1:0] r_raw, c_raw, c_wrap, r_cl, c_cl;
  logic signed [IW-1:0] n_rows, n_cols;
  assign n_rows = $signed(IW'(ctrl_rows_q));
  assign n_cols = $signed(IW'(ctrl_cols_q));
  assign r_raw  = $signed({1'b0, rseg_q}) + $signed(IW'(row_q)) - IW'(1);
  assign c_raw  = $signed({1'b0, cseg_q}) + $signed(IW'(col_q)) - IW'(1);

  always_comb begin
    if (r_raw < 0)            r_cl = '0;
    else if (r_raw >= n_rows) r_cl = n_rows - IW'(1);
    else                      r_cl = r_raw;
    if (c_raw < 0)            c_wrap = c_raw + n_cols;
    else if (c_raw >= n_cols) c_wrap = c_raw - n_cols;
    else                      c_wrap = c_raw;
    if (c_raw < 0)            c_cl = '0;
    else if (c_raw >= n_cols) c_cl = n_cols - IW'(1);
    else                      c_cl = c_raw;
  end

  logic [RIW-1:0] r_idx;
  logic [CIW-1:0] c_idx;
  assign r_idx = RIW'(r_cl);
  assign c_idx = periodic_q ? CIW'(c_wrap) : CIW'(c_cl);
  assign raddr = AW'(32'(r_idx) * MAX_CONTROL_COLUMNS + 32'(c_idx));
  assign rd_en = (state_q == S_RD);

  // shared cubic unit
  logic                 cub_start, cub_done;
  logic signed [VW-1:0] cp [4];
  logic signed [VW-1:0] cub_val, sat_val;
  logic [FRAC_W-1:0]    cub_t;

  assign cub_start = (state_q == S_CST);
  assign cub_t     = fin_q ? rt_q : ct_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cp[j] = fin_q ? rv_q[j][axis_q] : VW'(pts_q[j][axis_q]);
    end
  end

  bcr_cubic #(.VW(VW)) u_cubic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cub_start),
    .p0_i    (cp[0]),
    .p1_i    (cp[1]),
    .p2_i    (cp[2]),
    .p3_i    (cp[3]),
    .t_i     (cub_t),
    .done_o  (cub_done),
    .value_o (cub_val)
  );

  always_comb begin
    if (cub_val > SAT_MAX)      sat_val = SAT_MAX;
    else if (cub_val < SAT_MIN) sat_val = SAT_MIN;
    else                        sat_val = cub_val;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && func_i == FUNC_SAMPLE && cfg_ok && idx_ok) state_d = S_DIVR;
      S_DIVR: if (cnt_q == 5'(DW - 1)) state_d = S_DIVC;
      S_DIVC: if (cnt_q == 5'(DW - 1)) state_d = S_RD;
      S_RD:   state_d = S_CAP;
      S_CAP:  state_d = (col_q == 2'd3) ? S_CST : S_RD;
      S_CST:  state_d = S_CW;
      S_CW: begin
        if (cub_done) begin
          if (axis_q != 2'd2)    state_d = S_CST;
          else if (fin_q)        state_d = S_OUT;
          else if (row_q == 2'd3) state_d = S_CST;
          else                   state_d = S_RD;
        end
      end
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      cnt_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      axis_q   <= '0;
      fin_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && func_i == FUNC_SAMPLE) begin
            cnt_q  <= '0;
            row_q  <= '0;
            col_q  <= '0;
            axis_q <= '0;
            fin_q  <= 1'b0;
            if (!cfg_ok) begin
              done_q   <= 1'b1;
              status_q <= STATUS_BAD_CONFIG;
            end else if (!idx_ok) begin
              done_q   <= 1'b1;
              status_q <= STATUS_RANGE;
            end
          end
        end
        S_DIVR, S_DIVC: cnt_q <= (cnt_q == 5'(DW - 1)) ? 5'd0 : cnt_q + 5'd1;
        S_CAP: col_q <= col_q + 2'd1;
        S_CW: begin
          if (cub_done) begin
            if (axis_q != 2'd2) begin
              axis_q <= axis_q + 2'd1;
            end else begin
              axis_q <= '0;
              if (row_q == 2'd3) fin_q <= 1'b1;
              else row_q <= row_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          done_q   <= 1'b1;
          status_q <= STATUS_OK;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && func_i == FUNC_SAMPLE) begin
          scol_q <= sample_column_i;
          dvd_q  <= {num_row, FRAC_W'(0)};
          den_q  <= den_row;
          rem_q  <= '0;
          if (!cfg_ok || !idx_ok) begin
            for (int k = 0; k < 3; k++) out_q[k] <= '0;
          end
        end
      end
      S_DIVR, S_DIVC: begin
        if (cnt_q == 5'(DW - 1)) begin
          // quotient is {quo_q[DW-2:0], qbit}
          if (state_q == S_DIVR) begin
            rseg_q <= quo_q[IW-3+FRAC_W:FRAC_W-1];
            rt_q   <= {quo_q[FRAC_W-2:0], qbit};
            dvd_q  <= {num_col, FRAC_W'(0)};
            den_q  <= den_col;
            rem_q  <= '0;
          end else begin
            cseg_q <= quo_q[IW-3+FRAC_W:FRAC_W-1];
            ct_q   <= {quo_q[FRAC_W-2:0], qbit};
          end
        end else begin
          dvd_q <= dvd_q << 1;
          rem_q <= rem_nx;
          quo_q <= {quo_q[DW-2:0], qbit};
        end
      end
      S_CAP: begin
        pts_q[col_q][0] <= rdata_q[WW-1 -: COORD_BITS];
        pts_q[col_q][1] <= rdata_q[2*COORD_BITS-1 -: COORD_BITS];
        pts_q[col_q][2] <= rdata_q[COORD_BITS-1:0];
      end
      S_CW: begin
        if (cub_done) begin
          if (fin_q) out_q[axis_q] <= COORD_BITS'(sat_val);
          else       rv_q[row_q][axis_q] <= cub_val;
        end
      end
      default: ;
    endcase
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign x_out_o  = out_q[0];
  assign y_out_o  = out_q[1];
  assign z_out_o  = out_q[2];

  // a result beat only appears once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result beat while busy");

  // error results carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |-> (x_out_o == '0 && y_out_o == '0 && z_out_o == '0))
    else $error("error beat with nonzero coordinates");

  // the cubic unit reports only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) cub_done |-> state_q == S_CW)
    else $error("cubic result outside wait state");

endmodule
